// File: hdl/sle_pkg.sv
// Package: shared constants, codes and control types of the list engine.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int FOUND_W  = 7;
    localparam int COUNT_W  = 8;
    // common width for comparing position and count and for masking outputs
    localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_FIND   = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD       = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND_RD,
        S_FIND_CMP,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_WR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_POS,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_DEC,
        RD_INC
    } t_rd_sel;

    typedef enum logic {
        WR_VAL,
        WR_RDATA
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic    capture;
        t_idx_op idx_op;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_cnt_op cnt_op;
        logic    res_en;
        t_status res_status;
        logic    res_found;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic pos_gt_count;
        logic pos_ge_count;
        logic count_zero;
        logic match;
        logic find_last;
        logic ins_more;
        logic del_more;
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/sle_ram.sv
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/sle_datapath.sv
// Datapath: captured request, entry count, scan index, entry RAM and result registers.
`timescale 1ns / 1ps
`default_nettype none

module sle_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sle_pkg::t_cmd                  i_cmd,
    output sle_pkg::t_stat                      o_stat,
    input  wire logic [1:0]                     i_operation,
    input  wire logic [sle_pkg::POS_W-1:0]      i_position,
    input  wire logic signed [sle_pkg::VALUE_W-1:0] i_value,
    output logic [1:0]                          o_status,
    output logic [sle_pkg::FOUND_W-1:0]         o_found_index,
    output logic [sle_pkg::COUNT_W-1:0]         o_count
);

    sle_pkg::t_op                       r_op;
    logic [sle_pkg::POS_W-1:0]          r_pos;
    logic [sle_pkg::VALUE_W-1:0]        r_val;
    logic [sle_pkg::CNT_W-1:0]          r_count, n_count;
    logic [sle_pkg::CNT_W-1:0]          r_idx, n_idx;
    sle_pkg::t_status                   r_res_status;
    logic [sle_pkg::CNT_W-1:0]          r_res_idx;

    logic [sle_pkg::WIDE_W-1:0]         pos_w, count_w, idx_w, res_idx_w, out_cnt_w;
    logic [sle_pkg::CNT_W:0]            idx_p1;
    logic [sle_pkg::CNT_W-1:0]          rd_idx;
    logic [sle_pkg::ADDR_W-1:0]         rd_addr, wr_addr;
    logic [sle_pkg::VALUE_W-1:0]        wr_data, rd_data;

    assign pos_w   = sle_pkg::WIDE_W'(r_pos);
    assign count_w = sle_pkg::WIDE_W'(r_count);
    assign idx_w   = sle_pkg::WIDE_W'(r_idx);
    assign idx_p1  = {1'b0, r_idx} + (sle_pkg::CNT_W+1)'(1);

    always_comb begin
        o_stat.op           = r_op;
        o_stat.full         = (r_count >= sle_pkg::CNT_W'(sle_pkg::CAPACITY));
        o_stat.pos_gt_count = (pos_w > count_w);
        o_stat.pos_ge_count = (pos_w >= count_w);
        o_stat.count_zero   = (r_count == '0);
        o_stat.match        = (rd_data == r_val);
        o_stat.find_last    = (idx_p1 >= {1'b0, r_count});
        o_stat.ins_more     = (idx_w > pos_w);
        o_stat.del_more     = (idx_p1 < {1'b0, r_count});
    end

    // read address: current index or a neighbor
    always_comb begin
        case (i_cmd.rd_sel)
            sle_pkg::RD_DEC: rd_idx = r_idx - sle_pkg::CNT_W'(1);
            sle_pkg::RD_INC: rd_idx = idx_p1[sle_pkg::CNT_W-1:0];
            default:         rd_idx = r_idx;
        endcase
    end

    assign rd_addr = rd_idx[sle_pkg::ADDR_W-1:0];
    assign wr_addr = r_idx[sle_pkg::ADDR_W-1:0];
    assign wr_data = (i_cmd.wr_sel == sle_pkg::WR_VAL) ? r_val : rd_data;

    sle_ram #(
        .WIDTH(sle_pkg::VALUE_W),
        .DEPTH(sle_pkg::CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        case (i_cmd.idx_op)
            sle_pkg::IDX_ZERO:  n_idx = '0;
            sle_pkg::IDX_COUNT: n_idx = r_count;
            sle_pkg::IDX_POS:   n_idx = pos_w[sle_pkg::CNT_W-1:0];
            sle_pkg::IDX_INC:   n_idx = idx_p1[sle_pkg::CNT_W-1:0];
            sle_pkg::IDX_DEC:   n_idx = r_idx - sle_pkg::CNT_W'(1);
            default:            n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            sle_pkg::CNT_CLR: n_count = '0;
            sle_pkg::CNT_INC: n_count = r_count + sle_pkg::CNT_W'(1);
            sle_pkg::CNT_DEC: n_count = r_count - sle_pkg::CNT_W'(1);
            default:          n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.capture) begin
            r_op  <= sle_pkg::t_op'(i_operation);
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.res_en) begin
            r_res_status <= i_cmd.res_status;
            r_res_idx    <= i_cmd.res_found ? r_idx : '0;
        end
    end

    // outputs masked to their field widths
    assign res_idx_w = sle_pkg::WIDE_W'(r_res_idx);
    assign out_cnt_w = count_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status      <= r_res_status;
            o_found_index <= res_idx_w[sle_pkg::FOUND_W-1:0];
            o_count       <= out_cnt_w[sle_pkg::COUNT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hdl/sle_ctrl.sv
// Controller: sequences each operation and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module sle_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire sle_pkg::t_stat i_stat,
    output sle_pkg::t_cmd       o_cmd
);

    sle_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sle_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        o_in_stall       = 1'b1;
        o_cmd.capture    = 1'b0;
        o_cmd.idx_op     = sle_pkg::IDX_HOLD;
        o_cmd.rd_sel     = sle_pkg::RD_IDX;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_sel     = sle_pkg::WR_VAL;
        o_cmd.cnt_op     = sle_pkg::CNT_HOLD;
        o_cmd.res_en     = 1'b0;
        o_cmd.res_status = sle_pkg::ST_OK;
        o_cmd.res_found  = 1'b0;
        o_cmd.load_out   = 1'b0;
        n_out_valid      = r_out_valid && i_out_stall;

        case (r_state)
            sle_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = sle_pkg::S_DECODE;
                end
            end
            sle_pkg::S_DECODE: begin
                case (i_stat.op)
                    sle_pkg::OP_CLEAR: begin
                        o_cmd.cnt_op     = sle_pkg::CNT_CLR;
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_status = sle_pkg::ST_OK;
                        n_state          = sle_pkg::S_DONE;
                    end
                    sle_pkg::OP_FIND: begin
                        if (i_stat.count_zero) begin
                            o_cmd.res_en     = 1'b1;
                            o_cmd.res_status = sle_pkg::ST_NOT_FOUND;
                            n_state          = sle_pkg::S_DONE;
                        end else begin
                            o_cmd.idx_op = sle_pkg::IDX_ZERO;
                            n_state      = sle_pkg::S_FIND_RD;
                        end
                    end
                    sle_pkg::OP_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.res_en     = 1'b1;
                            o_cmd.res_status = sle_pkg::ST_FULL;
                            n_state          = sle_pkg::S_DONE;
                        end else if (i_stat.pos_gt_count) begin
                            o_cmd.res_en     = 1'b1;
                            o_cmd.res_status = sle_pkg::ST_BAD;
                            n_state          = sle_pkg::S_DONE;
                        end else begin
                            o_cmd.idx_op = sle_pkg::IDX_COUNT;
                            n_state      = sle_pkg::S_INS_CHK;
                        end
                    end
                    default: begin
                        if (i_stat.count_zero || i_stat.pos_ge_count) begin
                            o_cmd.res_en     = 1'b1;
                            o_cmd.res_status = sle_pkg::ST_BAD;
                            n_state          = sle_pkg::S_DONE;
                        end else begin
                            o_cmd.idx_op = sle_pkg::IDX_POS;
                            n_state      = sle_pkg::S_DEL_CHK;
                        end
                    end
                endcase
            end
            sle_pkg::S_FIND_RD: begin
                o_cmd.rd_sel = sle_pkg::RD_IDX;
                n_state      = sle_pkg::S_FIND_CMP;
            end
            sle_pkg::S_FIND_CMP: begin
                if (i_stat.match) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = sle_pkg::ST_OK;
                    o_cmd.res_found  = 1'b1;
                    n_state          = sle_pkg::S_DONE;
                end else if (i_stat.find_last) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = sle_pkg::ST_NOT_FOUND;
                    n_state          = sle_pkg::S_DONE;
                end else begin
                    o_cmd.idx_op = sle_pkg::IDX_INC;
                    n_state      = sle_pkg::S_FIND_RD;
                end
            end
            sle_pkg::S_INS_CHK: begin
                if (i_stat.ins_more) begin
                    o_cmd.rd_sel = sle_pkg::RD_DEC;
                    n_state      = sle_pkg::S_INS_WR;
                end else begin
                    // index has reached the position: drop the new value in
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_sel     = sle_pkg::WR_VAL;
                    o_cmd.cnt_op     = sle_pkg::CNT_INC;
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = sle_pkg::ST_OK;
                    n_state          = sle_pkg::S_DONE;
                end
            end
            sle_pkg::S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = sle_pkg::WR_RDATA;
                o_cmd.idx_op = sle_pkg::IDX_DEC;
                n_state      = sle_pkg::S_INS_CHK;
            end
            sle_pkg::S_DEL_CHK: begin
                if (i_stat.del_more) begin
                    o_cmd.rd_sel = sle_pkg::RD_INC;
                    n_state      = sle_pkg::S_DEL_WR;
                end else begin
                    o_cmd.cnt_op     = sle_pkg::CNT_DEC;
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = sle_pkg::ST_OK;
                    n_state          = sle_pkg::S_DONE;
                end
            end
            sle_pkg::S_DEL_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = sle_pkg::WR_RDATA;
                o_cmd.idx_op = sle_pkg::IDX_INC;
                n_state      = sle_pkg::S_DEL_CHK;
            end
            sle_pkg::S_DONE: begin
                // hand off once the output register is free or draining
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = sle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sle_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/sequential_list_engine_unit.sv
// Top level: ordered list engine with clear, find, insert and delete.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_operation, i_position, i_value
// out      output     o_out_valid / i_out_stall  o_status, o_found_index, o_count
//
// Sequence: each transaction passes through accept, decode and hand-off. Find reads
//   and compares each entry scanned; insert moves entries up one at a time, then
//   writes the new value; delete moves entries down one at a time; the error cases
//   go straight from decode to hand-off. The single-port-read entry RAM, one read and
//   one write per move step, sets this. No new transaction is taken until hand-off.
// Reset: synchronous, active low; the count and the handshakes clear, the entry
//   RAM is not cleared and needs no clearing pass.
// Stalls: the result register holds a finished transaction while a new one is
//   accepted and worked on; that one waits in its final state until out frees.

module sequential_list_engine_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_operation,
    input  wire logic [sle_pkg::POS_W-1:0]          i_position,
    input  wire logic signed [sle_pkg::VALUE_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [1:0]                              o_status,
    output logic [sle_pkg::FOUND_W-1:0]             o_found_index,
    output logic [sle_pkg::COUNT_W-1:0]             o_count
);

    // command and status buses between sequencer and datapath
    sle_pkg::t_cmd  cmd;
    sle_pkg::t_stat stat;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // entries live in RAM; count, index and result registers beside it
    sle_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_status     (o_status),
        .o_found_index(o_found_index),
        .o_count      (o_count)
    );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Testbench: self-checking stimulus and result scoreboard for the ordered list engine.
`timescale 1ns / 1ps

module testbench;

    // Generous cycle budget: covers full-list finds, plus stalls and gaps.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Long receiver hold-off: when it starts and how long it lasts.
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    // Idling stops for the last part of the run.
    localparam int QUIET_TAIL   = 200;
    // Drain after the last result, longer than the slowest transaction.
    localparam int SETTLE_CYCLES = 300;
    localparam int MAX_REPORTS  = 10;

    // One input transaction as the sender queues it.
    typedef struct {
        sle_pkg::t_op op;
        logic [7:0]   pos;
        logic [31:0]  value;
        bit           wait_drain;   // sender holds off until every result is back
    } t_list_cmd;

    // One predicted result.
    typedef struct {
        sle_pkg::t_status                   status;
        logic [sle_pkg::FOUND_W-1:0]        found_index;
        logic [sle_pkg::COUNT_W-1:0]        count;
    } t_list_resp;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [1:0]                          i_operation = '0;
    logic [sle_pkg::POS_W-1:0]           i_position = '0;
    logic signed [sle_pkg::VALUE_W-1:0]  i_value = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [1:0]                          o_status;
    logic [sle_pkg::FOUND_W-1:0]         o_found_index;
    logic [sle_pkg::COUNT_W-1:0]         o_count;

    sequential_list_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_count       (o_count)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow list: mirrors the engine contents for prediction.
    // ------------------------------------------------------------------
    logic [31:0]  list_mem [sle_pkg::CAPACITY];
    int unsigned  list_len = 0;

    t_list_cmd    cmd_queue[$];      // transactions not yet offered
    t_list_resp   resp_queue[$];     // predicted results, oldest first
    t_list_resp   oldest_resp;
    t_list_cmd    cur_cmd;

    int unsigned  n_taken = 0;       // input transactions accepted
    int unsigned  n_offered = 0;     // input transactions the driver has retired
    int unsigned  n_results = 0;     // output transactions accepted
    int unsigned  n_mismatch = 0;
    int unsigned  total_cmds = 0;
    int unsigned  cycle_count = 0;

    // Generator state: the list length as the queued stimulus will leave it.
    int unsigned  plan_len = 0;
    logic [31:0]  value_pool [16];

    // Applies one operation to the shadow list and returns the result it gives.
    function automatic t_list_resp apply_list_op(sle_pkg::t_op op, logic [7:0] pos,
                                                 logic [31:0] value);
        t_list_resp  r;
        int unsigned p;
        int unsigned i;
        r.status      = sle_pkg::ST_OK;
        r.found_index = '0;
        p = pos;
        case (op)
            sle_pkg::OP_CLEAR: begin
                // entries stay, only the length drops
                list_len = 0;
            end
            sle_pkg::OP_FIND: begin
                r.status = sle_pkg::ST_NOT_FOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == value) begin
                        r.status      = sle_pkg::ST_OK;
                        r.found_index = sle_pkg::FOUND_W'(i);
                        break;
                    end
                end
            end
            sle_pkg::OP_INSERT: begin
                // full wins over a bad position
                if (list_len >= sle_pkg::CAPACITY) begin
                    r.status = sle_pkg::ST_FULL;
                end else if (p > list_len) begin
                    r.status = sle_pkg::ST_BAD;
                end else begin
                    for (i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[p] = value;
                    list_len++;
                end
            end
            default: begin
                if (list_len == 0 || p >= list_len) begin
                    r.status = sle_pkg::ST_BAD;
                end else begin
                    for (i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
        endcase
        r.count = sle_pkg::COUNT_W'(list_len);
        return r;
    endfunction

    // Queues one transaction and tracks the resulting list length for planning.
    task automatic push_cmd(sle_pkg::t_op op, int unsigned pos, logic [31:0] value,
                            bit wait_drain = 1'b0);
        t_list_cmd c;
        c.op         = op;
        c.pos        = pos[7:0];
        c.value      = value;
        c.wait_drain = wait_drain;
        cmd_queue.push_back(c);
        case (op)
            sle_pkg::OP_CLEAR:  plan_len = 0;
            sle_pkg::OP_INSERT:
                if (plan_len < sle_pkg::CAPACITY && c.pos <= plan_len) plan_len++;
            sle_pkg::OP_DELETE: if (c.pos < plan_len) plan_len--;
            default: ;
        endcase
    endtask

    // Half the values come from a small pool so finds hit and duplicates occur.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(1, 0) == 0)
            return value_pool[$urandom_range(15, 0)];
        return $urandom;
    endfunction

    // Mixed random traffic; mostly in-range positions, some out of range.
    task automatic gen_mixed(int n, int ins_pct, int del_pct);
        int r;
        int unsigned pos;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99, 0);
            if (r < 2) begin
                push_cmd(sle_pkg::OP_CLEAR, $urandom_range(255, 0), $urandom);
            end else if (r < 2 + ins_pct) begin
                if ($urandom_range(99, 0) < 88 || plan_len >= 255)
                    pos = $urandom_range(plan_len, 0);
                else
                    pos = $urandom_range(255, plan_len + 1);
                push_cmd(sle_pkg::OP_INSERT, pos, pick_value());
            end else if (r < 2 + ins_pct + del_pct) begin
                if (plan_len > 0 && $urandom_range(99, 0) < 88)
                    pos = $urandom_range(plan_len - 1, 0);
                else
                    pos = $urandom_range(255, plan_len);
                push_cmd(sle_pkg::OP_DELETE, pos, $urandom);
            end else begin
                push_cmd(sle_pkg::OP_FIND, $urandom_range(255, 0), pick_value());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued transactions, changes inputs at falling edges.
    // ------------------------------------------------------------------
    bit           presenting = 1'b0;
    int unsigned  gap_left = 0;
    bit           send_idle_ok;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // current transaction taken at the last rising edge
            if (presenting && n_taken != n_offered) begin
                presenting = 1'b0;
                n_offered++;
                // idle bursts, with quiet stretches and none in the tail
                send_idle_ok = (cmd_queue.size() > QUIET_TAIL) &&
                               ((n_offered / 50) % 4 != 3);
                if (send_idle_ok && $urandom_range(3, 0) == 0)
                    gap_left = $urandom_range(7, 1);
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_queue.size() > 0 &&
                             !(cmd_queue[0].wait_drain && resp_queue.size() != 0)) begin
                    cur_cmd    = cmd_queue.pop_front();
                    presenting = 1'b1;
                end
            end
        end
        i_in_valid <= presenting;
        if (presenting) begin
            i_operation <= cur_cmd.op;
            i_position  <= cur_cmd.pos;
            i_value     <= cur_cmd.value;
        end else begin
            // junk payload while idle; the engine must ignore it
            i_operation <= 2'($urandom);
            i_position  <= 8'($urandom);
            i_value     <= $urandom;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random bursts plus one long hold-off that backs the
    // engine up until it stalls its input.
    // ------------------------------------------------------------------
    int unsigned  hold_left = 0;
    bit           hold_done = 1'b0;
    int unsigned  stall_left = 0;
    bit           stall_now;

    always @(negedge i_clk) begin
        stall_now = 1'b0;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                stall_now = 1'b1;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                stall_now = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_now = 1'b1;
            end else if (total_cmds > n_results + QUIET_TAIL &&
                         (n_results / 60) % 4 != 1 &&
                         $urandom_range(4, 0) == 0) begin
                stall_left = $urandom_range(7, 1) - 1;
                stall_now  = 1'b1;
            end
        end
        i_out_stall <= stall_now;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted input, checks each accepted output.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                resp_queue.push_back(apply_list_op(sle_pkg::t_op'(i_operation),
                                                   i_position, i_value));
                n_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (resp_queue.size() == 0) begin
                    if (n_mismatch < MAX_REPORTS)
                        $display("ERROR: unexpected result: status %0d index %0d count %0d",
                                 o_status, o_found_index, o_count);
                    n_mismatch++;
                end else begin
                    oldest_resp = resp_queue.pop_front();
                    if (o_status !== oldest_resp.status ||
                        o_found_index !== oldest_resp.found_index ||
                        o_count !== oldest_resp.count) begin
                        if (n_mismatch < MAX_REPORTS)
                            $display("ERROR: result %0d (status/index/count): %s",
                                     n_results,
                                     $sformatf("expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                               oldest_resp.status,
                                               oldest_resp.found_index,
                                               oldest_resp.count,
                                               o_status, o_found_index, o_count));
                        n_mismatch++;
                    end
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run.
    // ------------------------------------------------------------------
    initial begin
        int ins_mix [8];
        int del_mix [8];
        ins_mix = '{30, 55, 20, 40, 65, 25, 45, 35};
        del_mix = '{30, 15, 55, 40, 10, 50, 35, 30};

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int k = 4; k < 16; k++)
            value_pool[k] = $urandom;

        // Directed: empty-list cases, extremes, append, duplicates, clear.
        push_cmd(sle_pkg::OP_FIND,   0,   32'd5);            // find on empty
        push_cmd(sle_pkg::OP_DELETE, 0,   32'd0);            // delete from empty
        push_cmd(sle_pkg::OP_INSERT, 1,   32'd9);            // position past count
        push_cmd(sle_pkg::OP_INSERT, 0,   32'h8000_0000);
        push_cmd(sle_pkg::OP_INSERT, 1,   32'h7FFF_FFFF);    // append at count
        push_cmd(sle_pkg::OP_INSERT, 0,   32'hFFFF_FFFF);    // shift everything up
        push_cmd(sle_pkg::OP_INSERT, 2,   32'h0000_0000);    // middle
        push_cmd(sle_pkg::OP_FIND,   255, 32'h7FFF_FFFF);
        push_cmd(sle_pkg::OP_FIND,   0,   32'hFFFF_FFFF);
        push_cmd(sle_pkg::OP_FIND,   0,   32'd5);            // no match
        push_cmd(sle_pkg::OP_INSERT, 255, 32'd1);
        push_cmd(sle_pkg::OP_INSERT, 5,   32'd1);
        push_cmd(sle_pkg::OP_DELETE, 4,   32'd0);            // position equal to count
        push_cmd(sle_pkg::OP_DELETE, 255, 32'd0);
        push_cmd(sle_pkg::OP_DELETE, 0,   32'd0);
        push_cmd(sle_pkg::OP_INSERT, 3,   32'h0000_0000);    // duplicate at the end
        push_cmd(sle_pkg::OP_FIND,   0,   32'h0000_0000);    // lowest index wins
        push_cmd(sle_pkg::OP_DELETE, 3,   32'd0);            // last entry
        push_cmd(sle_pkg::OP_CLEAR,  255, 32'hFFFF_FFFF);
        push_cmd(sle_pkg::OP_FIND,   0,   32'h8000_0000);    // old entries not visible
        push_cmd(sle_pkg::OP_DELETE, 0,   32'd0);
        push_cmd(sle_pkg::OP_INSERT, 0,   32'h5555_5555);
        push_cmd(sle_pkg::OP_INSERT, 1,   32'hAAAA_AAAA);
        push_cmd(sle_pkg::OP_FIND,   0,   32'hAAAA_AAAA);

        // Fill to capacity, then hit the full-list cases.
        while (plan_len < sle_pkg::CAPACITY)
            push_cmd(sle_pkg::OP_INSERT, $urandom_range(plan_len, 0), pick_value());
        push_cmd(sle_pkg::OP_INSERT, 0,   $urandom);         // full
        push_cmd(sle_pkg::OP_INSERT, 200, $urandom);         // full beats bad position
        push_cmd(sle_pkg::OP_FIND,   0,   $urandom);         // whole-list scan
        push_cmd(sle_pkg::OP_FIND,   0,   value_pool[1]);
        push_cmd(sle_pkg::OP_DELETE, sle_pkg::CAPACITY - 1, 32'd0);
        push_cmd(sle_pkg::OP_INSERT, sle_pkg::CAPACITY - 1, value_pool[0]);
        push_cmd(sle_pkg::OP_DELETE, 0,   32'd0);
        push_cmd(sle_pkg::OP_INSERT, sle_pkg::CAPACITY, $urandom);    // past count by one

        // Random phases with shifting mixes; one sender drain midway.
        for (int s = 0; s < 8; s++) begin
            if (s == 4)
                push_cmd(sle_pkg::OP_FIND, 0, pick_value(), 1'b1);
            gen_mixed(215, ins_mix[s], del_mix[s]);
        end
        total_cmds = cmd_queue.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || presenting || resp_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0 && resp_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
